### rtl/bba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Shared codes and field widths of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 17;
  localparam int ORDER_W = 5;
  localparam int STAT_W  = 2;
  localparam int CIDX_W  = 1;

  // commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADADDR = 2'd2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_BASE_ADDRESS = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_MIN_ORDER    = 1'd1;

  localparam logic [ORDER_W-1:0] MIN_ORDER_RESET = 5'd5;
  // tag value of a granule that starts no allocated block
  localparam logic [ORDER_W-1:0] NO_TAG = 5'd31;

endpackage

`default_nettype wire

### rtl/buddy_block_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Binary buddy allocator over a pool of 2^POOL_ORDER bytes.
// ----------------------------------------------------------------------------
// The buddy tree is kept in one node memory: each node holds a bit per level
// telling whether a free block of that level lies in its subtree, so the
// root shows at once which orders are available and a walk down the left-most
// matching path finds the lowest free block. A second memory holds the order
// tag of every granule. Both memories have one read and one write port with a
// registered read. An allocate searches, splits and updates the ancestors;
// a free merges and updates the ancestors; errors go straight to the result.
// One item is in work at a time; the next is taken as soon as its result sits
// in the output register. After reset a clearing pass initializes both
// memories while in_stall is high.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core
  import bba_pkg::*;
#(
  parameter int POOL_ORDER     = 16,
  parameter int MIN_UNIT_ORDER = 4
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      cfg_we,
  input  wire  [CIDX_W-1:0]        cfg_index,
  input  wire  [ADDR_W-1:0]        cfg_data,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire                      in_cmd,
  input  wire  [SIZE_W-1:0]        in_request_size,
  input  wire  [ADDR_W-1:0]        in_block_address,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic [ADDR_W-1:0]        out_address,
  output logic [STAT_W-1:0]        out_status,
  output logic [ORDER_W-1:0]       out_order,
  output logic [SIZE_W-1:0]        out_free_bytes
);

  localparam int LV        = POOL_ORDER - MIN_UNIT_ORDER + 1;
  localparam int NW        = LV;
  localparam int NODES     = (1 << LV) - 1;
  localparam int TW        = LV - 1;
  localparam int TAG_DEPTH = 1 << TW;
  localparam int OW        = POOL_ORDER;
  localparam int CW        = POOL_ORDER + 1;
  localparam int JW        = (LV > 1) ? $clog2(LV) : 1;
  localparam logic [LV-1:0] TOP_BIT    = LV'(1) << (LV - 1);
  localparam logic [CW-1:0] POOL_BYTES = CW'(1) << POOL_ORDER;

  typedef enum logic [13:0] {
    S_CLR   = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_AROOT = 14'b00000000000100,
    S_ADESC = 14'b00000000001000,
    S_ASTEP = 14'b00000000010000,
    S_SPLA  = 14'b00000000100000,
    S_SPLB  = 14'b00000001000000,
    S_FTAG  = 14'b00000010000000,
    S_MRD   = 14'b00000100000000,
    S_MCHK  = 14'b00001000000000,
    S_MSET  = 14'b00010000000000,
    S_CLRD  = 14'b00100000000000,
    S_CLWR  = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   base_r;
  logic [ORDER_W-1:0]  min_order_r;
  logic [NW-1:0]       node_r, node_nxt;
  logic [NW-1:0]       top_node_r, top_node_nxt;
  logic [JW-1:0]       jc_r, jc_nxt;
  logic [JW-1:0]       lj_r, lj_nxt;
  logic [JW-1:0]       wj_r, wj_nxt;
  logic [ORDER_W-1:0]  want_r, want_nxt;
  logic [OW-1:0]       off_r, off_nxt;
  logic [LV-1:0]       mask_r, mask_nxt;
  logic [NW-1:0]       clr_r, clr_nxt;
  logic [CW-1:0]       free_cnt_r, free_cnt_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic [STAT_W-1:0]   res_status_r, res_status_nxt;
  logic [ORDER_W-1:0]  res_order_r, res_order_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_address_r, out_address_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [ORDER_W-1:0]  out_order_r, out_order_nxt;
  logic [SIZE_W-1:0]   out_free_r, out_free_nxt;

  // node mask memory and granule tag memory
  logic [LV-1:0]       mask_mem [NODES];
  logic [ORDER_W-1:0]  tag_mem  [TAG_DEPTH];
  logic                m_we, m_re;
  logic [NW-1:0]       m_waddr, m_raddr;
  logic [LV-1:0]       m_wdata, m_rdata_r;
  logic                t_we, t_re;
  logic [TW-1:0]       t_waddr, t_raddr;
  logic [ORDER_W-1:0]  t_wdata, t_rdata_r;

  always_ff @(posedge clk) begin
    if (m_we) begin
      mask_mem[m_waddr] <= m_wdata;
    end
    if (m_re) begin
      m_rdata_r <= mask_mem[m_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tag_mem[t_waddr] <= t_wdata;
    end
    if (t_re) begin
      t_rdata_r <= tag_mem[t_raddr];
    end
  end

  // request order: ceil(log2(size)), clamped
  logic [SIZE_W-1:0]  size_m1;
  logic [ORDER_W-1:0] want_c;
  logic [ADDR_W-1:0]  off32;
  logic               free_bad;

  always_comb begin
    size_m1 = in_request_size - SIZE_W'(1);
    want_c  = '0;
    if (in_request_size > SIZE_W'(1)) begin
      for (int i = 0; i < SIZE_W; i++) begin
        if (size_m1[i]) begin
          want_c = ORDER_W'(i + 1);
        end
      end
    end
    if (want_c < min_order_r) begin
      want_c = min_order_r;
    end
    if (want_c < ORDER_W'(MIN_UNIT_ORDER)) begin
      want_c = ORDER_W'(MIN_UNIT_ORDER);
    end
    off32    = in_block_address - base_r;
    free_bad = ((off32 >> POOL_ORDER) != '0) ||
               ((off32 & ((ADDR_W'(1) << MIN_UNIT_ORDER) - ADDR_W'(1))) != '0);
  end

  // lowest level at or above the wanted one with a free block
  logic          lvl_found;
  logic [JW-1:0] lvl_sel;

  always_comb begin
    lvl_found = 1'b0;
    lvl_sel   = '0;
    for (int i = LV - 1; i >= 0; i--) begin
      if (m_rdata_r[i] && (JW'(i) >= wj_r)) begin
        lvl_found = 1'b1;
        lvl_sel   = JW'(i);
      end
    end
  end

  logic [ORDER_W-1:0] tag_v;
  logic               tag_bad;
  logic [ORDER_W-1:0] tag_depth;
  logic [NW-1:0]      sib_node, par_node, left_node, right_node;
  logic [LV-1:0]      split_mask;

  always_comb begin
    tag_v     = t_rdata_r;
    tag_bad   = (tag_v < ORDER_W'(MIN_UNIT_ORDER)) || (tag_v > ORDER_W'(POOL_ORDER)) ||
                ((off_r & OW'((CW'(1) << tag_v) - CW'(1))) != '0);
    tag_depth = ORDER_W'(POOL_ORDER) - tag_v;
    sib_node   = node_r[0] ? (node_r + NW'(1)) : (node_r - NW'(1));
    par_node   = (node_r - NW'(1)) >> 1;
    left_node  = NW'({node_r, 1'b1});
    right_node = NW'({node_r, 1'b0}) + NW'(2);
    // levels wj .. jc-1 hold a free buddy below a split node
    split_mask = ((LV'(1) << jc_r) - LV'(1)) & ~((LV'(1) << wj_r) - LV'(1));
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    node_nxt        = node_r;
    top_node_nxt    = top_node_r;
    jc_nxt          = jc_r;
    lj_nxt          = lj_r;
    wj_nxt          = wj_r;
    want_nxt        = want_r;
    off_nxt         = off_r;
    mask_nxt        = mask_r;
    clr_nxt         = clr_r;
    free_cnt_nxt    = free_cnt_r;
    res_addr_nxt    = res_addr_r;
    res_status_nxt  = res_status_r;
    res_order_nxt   = res_order_r;
    out_address_nxt = out_address_r;
    out_status_nxt  = out_status_r;
    out_order_nxt   = out_order_r;
    out_free_nxt    = out_free_r;
    out_valid_nxt   = out_valid_r && out_stall;
    m_we    = 1'b0;
    m_waddr = node_r;
    m_wdata = '0;
    m_re    = 1'b0;
    m_raddr = node_r;
    t_we    = 1'b0;
    t_waddr = TW'(off_r >> MIN_UNIT_ORDER);
    t_wdata = NO_TAG;
    t_re    = 1'b0;
    t_raddr = TW'(off32 >> MIN_UNIT_ORDER);

    case (state_r)
      S_CLR: begin
        m_we    = 1'b1;
        m_waddr = clr_r;
        m_wdata = (clr_r == '0) ? TOP_BIT : '0;
        if (clr_r < NW'(TAG_DEPTH)) begin
          t_we    = 1'b1;
          t_waddr = TW'(clr_r);
        end
        if (clr_r == NW'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + NW'(1);
        end
      end
      S_IDLE: begin
        res_addr_nxt  = '0;
        res_order_nxt = '0;
        if (in_valid) begin
          if (in_cmd == CMD_ALLOC) begin
            if (want_c > ORDER_W'(POOL_ORDER)) begin
              res_status_nxt = ST_NOSPACE;
              state_nxt      = S_FIN;
            end else begin
              want_nxt  = want_c;
              wj_nxt    = JW'(want_c - ORDER_W'(MIN_UNIT_ORDER));
              m_re      = 1'b1;
              m_raddr   = '0;
              state_nxt = S_AROOT;
            end
          end else begin
            if (free_bad) begin
              res_status_nxt = ST_BADADDR;
              state_nxt      = S_FIN;
            end else begin
              t_re      = 1'b1;
              off_nxt   = OW'(off32);
              state_nxt = S_FTAG;
            end
          end
        end
      end
      S_AROOT: begin
        if (!lvl_found) begin
          res_status_nxt = ST_NOSPACE;
          state_nxt      = S_FIN;
        end else begin
          lj_nxt    = lvl_sel;
          jc_nxt    = JW'(LV - 1);
          node_nxt  = '0;
          off_nxt   = '0;
          state_nxt = S_ADESC;
        end
      end
      S_ADESC: begin
        if (jc_r == lj_r) begin
          top_node_nxt   = node_r;
          mask_nxt       = split_mask;
          t_we           = 1'b1;
          t_wdata        = want_r;
          free_cnt_nxt   = free_cnt_r - (CW'(1) << want_r);
          res_addr_nxt   = base_r + ADDR_W'(off_r);
          res_status_nxt = ST_OK;
          res_order_nxt  = want_r;
          state_nxt      = S_SPLA;
        end else begin
          m_re      = 1'b1;
          m_raddr   = left_node;
          state_nxt = S_ASTEP;
        end
      end
      S_ASTEP: begin
        if (m_rdata_r[lj_r]) begin
          node_nxt = left_node;
        end else begin
          node_nxt = right_node;
          off_nxt  = off_r | (OW'(1) << (ORDER_W'(jc_r) + ORDER_W'(MIN_UNIT_ORDER - 1)));
        end
        jc_nxt    = jc_r - JW'(1);
        state_nxt = S_ADESC;
      end
      S_SPLA: begin
        m_we    = 1'b1;
        m_waddr = node_r;
        m_wdata = split_mask;
        if (jc_r == wj_r) begin
          node_nxt  = top_node_r;
          state_nxt = S_CLRD;
        end else begin
          state_nxt = S_SPLB;
        end
      end
      S_SPLB: begin
        // upper half becomes a free buddy
        m_we      = 1'b1;
        m_waddr   = right_node;
        m_wdata   = LV'(1) << (jc_r - JW'(1));
        node_nxt  = left_node;
        jc_nxt    = jc_r - JW'(1);
        state_nxt = S_SPLA;
      end
      S_FTAG: begin
        if (tag_bad) begin
          res_status_nxt = ST_BADADDR;
          state_nxt      = S_FIN;
        end else begin
          t_we           = 1'b1;
          free_cnt_nxt   = free_cnt_r + (CW'(1) << tag_v);
          jc_nxt         = JW'(tag_v - ORDER_W'(MIN_UNIT_ORDER));
          node_nxt       = (NW'(1) << tag_depth) - NW'(1) + NW'(off_r >> tag_v);
          res_status_nxt = ST_OK;
          res_order_nxt  = tag_v;
          state_nxt      = S_MRD;
        end
      end
      S_MRD: begin
        if (jc_r == JW'(LV - 1)) begin
          state_nxt = S_MSET;
        end else begin
          m_re      = 1'b1;
          m_raddr   = sib_node;
          state_nxt = S_MCHK;
        end
      end
      S_MCHK: begin
        if (m_rdata_r[jc_r]) begin
          // buddy is free: absorb it and move up
          m_we      = 1'b1;
          m_waddr   = sib_node;
          m_wdata   = '0;
          node_nxt  = par_node;
          jc_nxt    = jc_r + JW'(1);
          state_nxt = S_MRD;
        end else begin
          state_nxt = S_MSET;
        end
      end
      S_MSET: begin
        m_we      = 1'b1;
        m_waddr   = node_r;
        m_wdata   = LV'(1) << jc_r;
        mask_nxt  = LV'(1) << jc_r;
        state_nxt = S_CLRD;
      end
      S_CLRD: begin
        if (node_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          m_re      = 1'b1;
          m_raddr   = sib_node;
          state_nxt = S_CLWR;
        end
      end
      S_CLWR: begin
        m_we      = 1'b1;
        m_waddr   = par_node;
        m_wdata   = mask_r | m_rdata_r;
        mask_nxt  = mask_r | m_rdata_r;
        node_nxt  = par_node;
        state_nxt = S_CLRD;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_address_nxt = res_addr_r;
          out_status_nxt  = res_status_r;
          out_order_nxt   = res_order_r;
          out_free_nxt    = SIZE_W'(free_cnt_r);
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      free_cnt_r  <= POOL_BYTES;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      min_order_r <= MIN_ORDER_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_cnt_r  <= free_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_ADDRESS: base_r <= cfg_data;
          CFG_MIN_ORDER:    min_order_r <= cfg_data[ORDER_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r        <= node_nxt;
    top_node_r    <= top_node_nxt;
    jc_r          <= jc_nxt;
    lj_r          <= lj_nxt;
    wj_r          <= wj_nxt;
    want_r        <= want_nxt;
    off_r         <= off_nxt;
    mask_r        <= mask_nxt;
    res_addr_r    <= res_addr_nxt;
    res_status_r  <= res_status_nxt;
    res_order_r   <= res_order_nxt;
    out_address_r <= out_address_nxt;
    out_status_r  <= out_status_nxt;
    out_order_r   <= out_order_nxt;
    out_free_r    <= out_free_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_address    = out_address_r;
  assign out_status     = out_status_r;
  assign out_order      = out_order_r;
  assign out_free_bytes = out_free_r;

  // no same-entry read and write in one cycle on the node memory
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (m_we && m_re) |-> (m_waddr != m_raddr))
    else $error("node memory read and write hit the same entry");

  a_free_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= POOL_BYTES)
    else $error("free byte count above pool size");

  a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_address_r == '0 && out_order_r == '0))
    else $error("error result carries address or order");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted a beat without going busy");

endmodule

`default_nettype wire
